// File: rtl/krt_pkg.sv
// shared types and codes for the key record table
// no dependencies
`default_nettype none

package krt_pkg;

  localparam int TABLE_DEPTH = 64;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 64;
  localparam int IDX_W    = 6;
  localparam int ID_W     = 32;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_REGISTER  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE    = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_COUNT = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL           = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_ID_EXHAUSTED   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND      = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX      = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_NOT_CONFIGURED = 3'd6;

  localparam logic [ID_W-1:0]    ID_ALL_ONES    = '1;
  localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = '1;

  typedef struct packed {
    logic            valid;
    logic            present;
    logic [ID_W-1:0] assoc_id;
  } entry_flags_t;

endpackage

`default_nettype wire

// File: rtl/key_record_table.sv
// key record table top level: op sequencer, slot scan and result register
// uses krt_pkg and krt_store
//
//   channel  signals                    direction  payload
//   cfg      cfg_valid / cfg_ready      in         cfg_data (active_records)
//   in       in_valid / in_stall        in         op, key, entry_index, new_*
//   out      out_valid / out_stall      out        status .. occupancy
//
// register, lookup and delete read every slot in use once (n = min(active_records,
// TABLE_DEPTH) slots), then pass drain, write-back and put; in_stall stays high
// until the op is back in idle, so a new item waits until the last one leaves put
// update, set count, unknown ops and unconfigured ops go from accept straight to put
// after reset the memory is cleared entry by entry with in_stall high
// a held output item does not block accepting the next item; that item waits in put
`default_nettype none

module key_record_table #(
  parameter int KEY_BYTES   = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [krt_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [krt_pkg::OP_W-1:0]      op,
  input  wire logic [krt_pkg::KEY_W-1:0]     key,
  input  wire logic [krt_pkg::IDX_W-1:0]     entry_index,
  input  wire logic                          new_valid,
  input  wire logic [krt_pkg::ID_W-1:0]      new_assoc_id,
  input  wire logic                          new_inside,
  input  wire logic [krt_pkg::COUNT_W-1:0]   new_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [krt_pkg::STATUS_W-1:0]       status,
  output logic                               found,
  output logic [krt_pkg::IDX_W-1:0]          slot,
  output logic [krt_pkg::ID_W-1:0]           assoc_id_out,
  output logic                               inside_out,
  output logic [krt_pkg::COUNT_W-1:0]        occupancy
);
  import krt_pkg::*;

  localparam int KW = 8 * KEY_BYTES;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [SW-1:0] MAX_N = SW'(TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;
  localparam logic [2:0] ST_PUT   = 3'd4;

  logic [2:0]         state;
  logic [CFG_W-1:0]   active_records;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_read;

  logic [OP_W-1:0]    op_q;
  logic [KW-1:0]      key_q;
  logic [SW-1:0]      scan_addr;
  logic               rd_pend;
  logic [SW-1:0]      rd_idx;

  logic               dup;
  logic               free_found;
  logic [SW-1:0]      free_slot;
  logic [ID_W-1:0]    max_id;
  logic               hit;
  logic [SW-1:0]      hit_slot;
  logic [ID_W-1:0]    hit_id;
  logic               hit_inside;

  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [SW-1:0]       res_slot;
  logic [ID_W-1:0]     res_aid;
  logic                res_inside;

  logic [SW-1:0] ar_w;
  logic [SW-1:0] n_eff;
  logic [SW-1:0] idx_w;
  logic          accept;
  logic          bad_idx;
  logic          reg_ok;
  logic          busy;

  logic          rd_en;
  entry_flags_t  rd_flags;
  logic [KW-1:0] rd_key;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_flags_t  wr_flags;
  logic [KW-1:0] wr_key;

  assign ar_w       = SW'(active_records);
  assign n_eff      = (ar_w > MAX_N) ? MAX_N : ar_w;
  assign idx_w      = SW'(entry_index);
  assign bad_idx    = idx_w >= n_eff;
  assign in_stall   = (state != ST_IDLE) || busy;
  assign accept     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign count_read = (count == COUNT_ALL_ONES) ? '0 : count;
  assign reg_ok     = !dup && free_found && (max_id != ID_ALL_ONES);
  assign rd_en      = (state == ST_SCAN);

  krt_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW),
    .KW    (KW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (scan_addr[IW-1:0]),
    .rd_flags (rd_flags),
    .rd_key   (rd_key),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_flags (wr_flags),
    .wr_key   (wr_key),
    .busy     (busy)
  );

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_flags = '0;
    wr_key   = key_q;
    if (accept && (op == OP_UPDATE) && !bad_idx) begin
      wr_en    = 1'b1;
      wr_addr  = idx_w[IW-1:0];
      wr_flags = '{valid: new_valid, present: new_inside, assoc_id: new_assoc_id};
      wr_key   = key[KW-1:0];
    end else if (state == ST_WB) begin
      if ((op_q == OP_REGISTER) && reg_ok) begin
        wr_en    = 1'b1;
        wr_addr  = free_slot[IW-1:0];
        wr_flags = '{valid: 1'b1, present: 1'b0, assoc_id: max_id + 1'b1};
      end else if ((op_q == OP_DELETE) && hit) begin
        wr_en    = 1'b1;
        wr_addr  = hit_slot[IW-1:0];
        wr_flags = '{valid: 1'b0, present: 1'b0, assoc_id: hit_id};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_records <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_records <= cfg_data;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SCAN);
      if ((state == ST_PUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_REGISTER, OP_LOOKUP, OP_DELETE: begin
                state <= (n_eff == '0) ? ST_PUT : ST_SCAN;
              end
              OP_SET_COUNT: begin
                count <= new_count;
                state <= ST_PUT;
              end
              default: begin
                state <= ST_PUT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_addr == n_eff - 1'b1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_WB;
        end
        ST_WB: begin
          if ((op_q == OP_DELETE) && hit && hit_inside && (count_read != '0)) begin
            count <= count_read - 1'b1;
          end
          state <= ST_PUT;
        end
        ST_PUT: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item, scan and result datapath
  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
    if (state == ST_SCAN) begin
      scan_addr <= scan_addr + 1'b1;
    end
    if (accept) begin
      op_q       <= op;
      key_q      <= key[KW-1:0];
      scan_addr  <= '0;
      dup        <= 1'b0;
      free_found <= 1'b0;
      free_slot  <= '0;
      max_id     <= '0;
      hit        <= 1'b0;
      hit_slot   <= '0;
      hit_id     <= '0;
      hit_inside <= 1'b0;
      res_found  <= 1'b0;
      case (op)
        OP_REGISTER, OP_LOOKUP, OP_DELETE: begin
          res_status <= (n_eff == '0) ? STATUS_NOT_CONFIGURED : STATUS_OK;
        end
        OP_UPDATE: begin
          res_status <= bad_idx ? STATUS_BAD_INDEX : STATUS_OK;
        end
        default: begin
          res_status <= STATUS_OK;
        end
      endcase
      if ((op == OP_UPDATE) && !bad_idx) begin
        res_slot   <= idx_w;
        res_aid    <= new_assoc_id;
        res_inside <= new_inside;
      end else begin
        res_slot   <= '0;
        res_aid    <= '0;
        res_inside <= 1'b0;
      end
    end
    if (rd_pend) begin
      if (rd_flags.valid) begin
        if (rd_key == key_q) begin
          dup <= 1'b1;
          if (!hit) begin
            hit        <= 1'b1;
            hit_slot   <= rd_idx;
            hit_id     <= rd_flags.assoc_id;
            hit_inside <= rd_flags.present;
          end
        end
        if (rd_flags.assoc_id > max_id) begin
          max_id <= rd_flags.assoc_id;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_idx;
      end
    end
    if (state == ST_WB) begin
      if (op_q == OP_REGISTER) begin
        if (dup) begin
          res_status <= STATUS_DUPLICATE;
        end else if (!free_found) begin
          res_status <= STATUS_FULL;
        end else if (max_id == ID_ALL_ONES) begin
          res_status <= STATUS_ID_EXHAUSTED;
        end else begin
          res_slot <= free_slot;
          res_aid  <= max_id + 1'b1;
        end
      end else if (!hit) begin
        res_status <= STATUS_NOT_FOUND;
      end else begin
        res_found  <= 1'b1;
        res_slot   <= hit_slot;
        res_aid    <= hit_id;
        res_inside <= hit_inside;
      end
    end
    if ((state == ST_PUT) && (!out_valid || !out_stall)) begin
      status       <= res_status;
      found        <= res_found;
      slot         <= res_slot[IDX_W-1:0];
      assoc_id_out <= res_aid;
      inside_out   <= res_inside;
      occupancy    <= count_read;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) || (state == ST_DRAIN)) |-> !wr_en)
    else $error("memory written during a scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_addr < n_eff))
    else $error("scan address beyond slots in use");

  a_out_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_PUT))
    else $error("output item loaded outside the put state");

  a_wb_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |-> ($past(state) == ST_DRAIN) && !rd_pend)
    else $error("write-back before the last read was taken");
`endif

endmodule

`default_nettype wire

// File: rtl/krt_store.sv
// entry memory of the key record table: one write port, one registered read port
// clears every entry after reset; uses krt_pkg
`default_nettype none

module krt_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int KW    = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output krt_pkg::entry_flags_t     rd_flags,
  output logic [KW-1:0]             rd_key,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire krt_pkg::entry_flags_t wr_flags,
  input  wire logic [KW-1:0]        wr_key,
  output logic                      busy
);
  import krt_pkg::*;

  localparam int FW = $bits(entry_flags_t);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [FW+KW-1:0] mem [DEPTH];
  logic [FW+KW-1:0] rd_q;
  logic [AW-1:0]    clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == LAST) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {wr_flags, wr_key};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_flags = rd_q[FW+KW-1:KW];
  assign rd_key   = rd_q[KW-1:0];

endmodule

`default_nettype wire
